// ----- hw/rtl/ppusar_pkg.sv -----
`default_nettype none

package ppusar_pkg;

    // Command codes carried by each request.
    typedef enum logic [3:0] {
        CMD_CTRL_WR    = 4'd0,
        CMD_OTHER_WR   = 4'd1,
        CMD_SCROLL_WR  = 4'd2,
        CMD_ADDR_WR    = 4'd3,
        CMD_DATA_WR    = 4'd4,
        CMD_DATA_RD    = 4'd5,
        CMD_STATUS_RD  = 4'd6,
        CMD_INC_X      = 4'd7,
        CMD_INC_Y      = 4'd8,
        CMD_COPY_H     = 4'd9,
        CMD_COPY_V     = 4'd10,
        CMD_SET_VBLANK = 4'd11,
        CMD_CLR_VBLANK = 4'd12
    } cmd_t;

    // Masks, steps and limits applied to the address registers.
    localparam logic [15:0] CTRL_KEEP_MASK     = 16'hfcff;
    localparam logic [15:0] SCROLL2_KEEP_MASK  = 16'h0c1f;
    localparam logic [15:0] ADDR2_KEEP_MASK    = 16'h7f00;
    localparam logic [15:0] COARSE_X_CLR_MASK  = 16'hffe0;
    localparam logic [15:0] PALETTE_MASK       = 16'h3f00;
    localparam logic [15:0] COPY_H_KEEP_MASK   = 16'hfbe0;
    localparam logic [15:0] COPY_H_TAKE_MASK   = 16'h041f;
    localparam logic [15:0] COPY_V_KEEP_MASK   = 16'h841f;
    localparam logic [15:0] COPY_V_TAKE_MASK   = 16'h7be0;
    localparam logic [15:0] FINE_Y_CLR_MASK    = 16'h8fff;
    localparam logic [15:0] ADDR1_KEEP_MASK    = 16'h00ff;
    localparam logic [15:0] COARSE_Y_CLR_MASK  = 16'hfc1f;
    localparam logic [15:0] NAMETABLE_X_BIT    = 16'h0400;
    localparam logic [15:0] NAMETABLE_Y_BIT    = 16'h0800;
    localparam logic [15:0] FINE_Y_STEP        = 16'h1000;
    localparam logic [15:0] ROW_STEP           = 16'd32;
    localparam logic [15:0] COLUMN_STEP        = 16'd1;
    localparam logic [4:0]  COARSE_MAX         = 5'h1f;
    localparam logic [4:0]  LAST_VISIBLE_ROW   = 5'd29;
    localparam logic [2:0]  FINE_Y_MAX         = 3'd7;

    // One accepted request.
    typedef struct packed {
        logic [3:0] command;
        logic [7:0] write_data;
        logic [7:0] read_data;
        logic       sprite_zero_hit;
        logic       sprite_overflow;
    } request_t;

    // One result.
    typedef struct packed {
        logic [7:0]  read_value;
        logic [13:0] vram_address;
        logic        vram_write;
        logic [7:0]  vram_write_data;
        logic [15:0] current_address;
        logic [2:0]  fine_x_scroll;
        logic        vblank_flag;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ppusar_in_reg.sv -----
`default_nettype none

module ppusar_in_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [3:0]          s_command,
    input  wire logic [7:0]          s_write_data,
    input  wire logic [7:0]          s_read_data,
    input  wire logic                s_sprite_zero_hit,
    input  wire logic                s_sprite_overflow,
    input  wire logic                advance,
    output logic                     req_valid,
    output ppusar_pkg::request_t     req
);

    logic                 valid_reg;
    logic                 valid_next;
    ppusar_pkg::request_t req_reg;

    // The slot frees up in the same cycle that its request moves on.
    assign s_ready   = !valid_reg || advance;
    assign req_valid = valid_reg;
    assign req       = req_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.command         <= s_command;
            req_reg.write_data      <= s_write_data;
            req_reg.read_data       <= s_read_data;
            req_reg.sprite_zero_hit <= s_sprite_zero_hit;
            req_reg.sprite_overflow <= s_sprite_overflow;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ppusar_core.sv -----
`default_nettype none

module ppusar_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire ppusar_pkg::request_t req,
    output ppusar_pkg::result_t       res
);

    logic [15:0] cur_reg,  cur_next;
    logic [15:0] tmp_reg,  tmp_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        second_reg, second_next;
    logic        by_row_reg, by_row_next;
    logic [7:0]  buffer_reg, buffer_next;
    logic [7:0]  last_reg, last_next;
    logic        vblank_reg, vblank_next;

    ppusar_pkg::cmd_t cmd;
    logic [7:0]  d;
    logic [15:0] step_amount;
    logic [15:0] y_wrapped;
    logic [4:0]  row;
    logic [4:0]  row_next;
    logic [15:0] y_cleared;
    logic [7:0]  rv;
    logic        wr;
    logic [7:0]  wd;

    assign cmd = ppusar_pkg::cmd_t'(req.command);
    assign d   = req.write_data;

    // Step applied by a data access.
    assign step_amount = by_row_reg ? ppusar_pkg::ROW_STEP : ppusar_pkg::COLUMN_STEP;

    // Vertical increment once fine Y has rolled over.
    always_comb begin
        y_cleared = cur_reg & ppusar_pkg::FINE_Y_CLR_MASK;
        row       = cur_reg[9:5];
        y_wrapped = y_cleared;
        if (row == ppusar_pkg::LAST_VISIBLE_ROW) begin
            row_next  = 5'd0;
            y_wrapped = y_cleared ^ ppusar_pkg::NAMETABLE_Y_BIT;
        end else if (row == ppusar_pkg::COARSE_MAX) begin
            row_next = 5'd0;
        end else begin
            row_next = row + 5'd1;
        end
    end

    // Command decode and next state.
    always_comb begin
        cur_next    = cur_reg;
        tmp_next    = tmp_reg;
        fine_x_next = fine_x_reg;
        second_next = second_reg;
        by_row_next = by_row_reg;
        buffer_next = buffer_reg;
        last_next   = last_reg;
        vblank_next = vblank_reg;
        rv          = 8'd0;
        wr          = 1'b0;
        wd          = 8'd0;

        case (cmd)
            ppusar_pkg::CMD_CTRL_WR: begin
                last_next   = d;
                by_row_next = d[2];
                tmp_next    = (tmp_reg & ppusar_pkg::CTRL_KEEP_MASK)
                            | {4'd0, d[1:0], 10'd0};
            end
            ppusar_pkg::CMD_OTHER_WR: begin
                last_next = d;
            end
            ppusar_pkg::CMD_SCROLL_WR: begin
                last_next = d;
                if (second_reg) begin
                    tmp_next    = (tmp_reg & ppusar_pkg::SCROLL2_KEEP_MASK)
                                | {1'b0, d[2:0], 2'd0, d[7:3], 5'd0};
                    second_next = 1'b0;
                end else begin
                    tmp_next    = (tmp_reg & ppusar_pkg::COARSE_X_CLR_MASK)
                                | {11'd0, d[7:3]};
                    fine_x_next = d[2:0];
                    second_next = 1'b1;
                end
            end
            ppusar_pkg::CMD_ADDR_WR: begin
                last_next = d;
                if (second_reg) begin
                    tmp_next    = (tmp_reg & ppusar_pkg::ADDR2_KEEP_MASK) | {8'd0, d};
                    cur_next    = (tmp_reg & ppusar_pkg::ADDR2_KEEP_MASK) | {8'd0, d};
                    second_next = 1'b0;
                end else begin
                    tmp_next    = (tmp_reg & ppusar_pkg::ADDR1_KEEP_MASK)
                                | {2'd0, d[5:0], 8'd0};
                    second_next = 1'b1;
                end
            end
            ppusar_pkg::CMD_DATA_WR: begin
                last_next = d;
                wr        = 1'b1;
                wd        = d;
                cur_next  = cur_reg + step_amount;
            end
            ppusar_pkg::CMD_DATA_RD: begin
                rv = ((cur_reg & ppusar_pkg::PALETTE_MASK) == ppusar_pkg::PALETTE_MASK)
                   ? req.read_data : buffer_reg;
                buffer_next = req.read_data;
                cur_next    = cur_reg + step_amount;
            end
            ppusar_pkg::CMD_STATUS_RD: begin
                rv = {vblank_reg, req.sprite_zero_hit, req.sprite_overflow, last_reg[4:0]};
                vblank_next = 1'b0;
                second_next = 1'b0;
            end
            ppusar_pkg::CMD_INC_X: begin
                if (cur_reg[4:0] == ppusar_pkg::COARSE_MAX) begin
                    cur_next = (cur_reg & ppusar_pkg::COARSE_X_CLR_MASK)
                             ^ ppusar_pkg::NAMETABLE_X_BIT;
                end else begin
                    cur_next = cur_reg + ppusar_pkg::COLUMN_STEP;
                end
            end
            ppusar_pkg::CMD_INC_Y: begin
                if (cur_reg[14:12] != ppusar_pkg::FINE_Y_MAX) begin
                    cur_next = cur_reg + ppusar_pkg::FINE_Y_STEP;
                end else begin
                    cur_next = (y_wrapped & ppusar_pkg::COARSE_Y_CLR_MASK)
                             | {6'd0, row_next, 5'd0};
                end
            end
            ppusar_pkg::CMD_COPY_H: begin
                cur_next = (cur_reg & ppusar_pkg::COPY_H_KEEP_MASK)
                         | (tmp_reg & ppusar_pkg::COPY_H_TAKE_MASK);
            end
            ppusar_pkg::CMD_COPY_V: begin
                cur_next = (cur_reg & ppusar_pkg::COPY_V_KEEP_MASK)
                         | (tmp_reg & ppusar_pkg::COPY_V_TAKE_MASK);
            end
            ppusar_pkg::CMD_SET_VBLANK: begin
                vblank_next = 1'b1;
            end
            ppusar_pkg::CMD_CLR_VBLANK: begin
                vblank_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Result of the request being processed.
    always_comb begin
        res.read_value      = rv;
        res.vram_address    = cur_reg[13:0];
        res.vram_write      = wr;
        res.vram_write_data = wd;
        res.current_address = cur_next;
        res.fine_x_scroll   = fine_x_next;
        res.vblank_flag     = vblank_next;
    end

    // Architectural state, updated once per processed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= 16'd0;
            tmp_reg    <= 16'd0;
            fine_x_reg <= 3'd0;
            second_reg <= 1'b0;
            by_row_reg <= 1'b0;
            buffer_reg <= 8'd0;
            last_reg   <= 8'd0;
            vblank_reg <= 1'b0;
        end else if (step) begin
            cur_reg    <= cur_next;
            tmp_reg    <= tmp_next;
            fine_x_reg <= fine_x_next;
            second_reg <= second_next;
            by_row_reg <= by_row_next;
            buffer_reg <= buffer_next;
            last_reg   <= last_next;
            vblank_reg <= vblank_next;
        end
    end

    // A status read always leaves vblank and the write toggle clear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && (cmd == ppusar_pkg::CMD_STATUS_RD) |=> !vblank_reg && !second_reg)
        else $error("status read did not clear vblank and toggle");

    // The second address write loads the current address from the temporary one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step && (cmd == ppusar_pkg::CMD_ADDR_WR) && second_reg |=> cur_reg == tmp_reg)
        else $error("address write did not copy temporary address");

    // Only a data write drives a memory write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.vram_write |-> cmd == ppusar_pkg::CMD_DATA_WR)
        else $error("memory write on a non-write command");

    // State holds while no request is processed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(cur_reg) && $stable(tmp_reg) && $stable(vblank_reg))
        else $error("state changed without a request");

endmodule

`default_nettype wire

// ----- hw/rtl/ppusar_out_reg.sv -----
`default_nettype none

module ppusar_out_reg (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire ppusar_pkg::result_t res,
    output logic                     can_take,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_read_value,
    output logic [13:0]              m_vram_address,
    output logic                     m_vram_write,
    output logic [7:0]               m_vram_write_data,
    output logic [15:0]              m_current_address,
    output logic [2:0]               m_fine_x_scroll,
    output logic                     m_vblank_flag
);

    logic                valid_reg;
    logic                valid_next;
    ppusar_pkg::result_t res_reg;

    // A new result may enter when the slot is empty or is being drained.
    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid           = valid_reg;
    assign m_read_value      = res_reg.read_value;
    assign m_vram_address    = res_reg.vram_address;
    assign m_vram_write      = res_reg.vram_write;
    assign m_vram_write_data = res_reg.vram_write_data;
    assign m_current_address = res_reg.current_address;
    assign m_fine_x_scroll   = res_reg.fine_x_scroll;
    assign m_vblank_flag     = res_reg.vblank_flag;

endmodule

`default_nettype wire

// ----- hw/rtl/ppu_scroll_address_registers.sv -----
// Path: a request in the input register passes the combinational command logic and its
// result is registered in the result register. Throughput: one request per cycle while
// m_ready drains the result register; input and result register each hold one request.
// Reset: aresetn is synchronous and active low; it clears the valid flags of both stages
// and all scroll, address, buffer and vblank registers to zero.
`default_nettype none

module ppu_scroll_address_registers (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [3:0]  s_command,
    input  wire logic [7:0]  s_write_data,
    input  wire logic [7:0]  s_read_data,
    input  wire logic        s_sprite_zero_hit,
    input  wire logic        s_sprite_overflow,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_value,
    output logic [13:0]      m_vram_address,
    output logic             m_vram_write,
    output logic [7:0]       m_vram_write_data,
    output logic [15:0]      m_current_address,
    output logic [2:0]       m_fine_x_scroll,
    output logic             m_vblank_flag
);

    logic                 req_valid;
    ppusar_pkg::request_t req;
    ppusar_pkg::result_t  res;
    logic                 can_take;
    logic                 advance;

    // A request moves on when the result register has room for it.
    assign advance = req_valid && can_take;

    ppusar_in_reg u_in_reg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_write_data      (s_write_data),
        .s_read_data       (s_read_data),
        .s_sprite_zero_hit (s_sprite_zero_hit),
        .s_sprite_overflow (s_sprite_overflow),
        .advance           (advance),
        .req_valid         (req_valid),
        .req               (req)
    );

    ppusar_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .req     (req),
        .res     (res)
    );

    ppusar_out_reg u_out_reg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (advance),
        .res               (res),
        .can_take          (can_take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_value      (m_read_value),
        .m_vram_address    (m_vram_address),
        .m_vram_write      (m_vram_write),
        .m_vram_write_data (m_vram_write_data),
        .m_current_address (m_current_address),
        .m_fine_x_scroll   (m_fine_x_scroll),
        .m_vblank_flag     (m_vblank_flag)
    );

endmodule

`default_nettype wire
